FILE: rtl/tlr_pkg.sv
// ----------------------------------------------------------------------------
// tlr_pkg: shared types and constants of the thick line rasterizer
// Coordinate and width sizes, request codes and the item structs of the
// request and response channels.
// ----------------------------------------------------------------------------
package tlr_pkg;

   // field widths
   localparam int COORD_BITS = 10;
   localparam int WIDTH_BITS = 6;
   localparam int PIX_BITS   = 12;

   // internal widths derived from the field widths
   localparam int IDX_BITS  = WIDTH_BITS + 1;
   localparam int MUL_BITS  = COORD_BITS + WIDTH_BITS + 2;
   localparam int PROD_BITS = 2 * MUL_BITS;
   localparam int LIM_BITS  = 2 * (COORD_BITS + WIDTH_BITS) + 1;
   localparam int CUR_BITS  = (COORD_BITS + 1 > PIX_BITS) ? COORD_BITS + 1 : PIX_BITS;
   localparam int ERR_BITS  = COORD_BITS + 3;

   // request codes
   localparam logic REQ_START = 1'b0;
   localparam logic REQ_STEP  = 1'b1;

   typedef struct packed {
      logic                  req_type;
      logic [COORD_BITS-1:0] x_start;
      logic [COORD_BITS-1:0] y_start;
      logic [COORD_BITS-1:0] x_end;
      logic [COORD_BITS-1:0] y_end;
      logic [WIDTH_BITS-1:0] line_width;
   } tlr_req_type;

   typedef struct packed {
      logic signed [PIX_BITS-1:0] pixel_x;
      logic signed [PIX_BITS-1:0] pixel_y;
      logic                       last_pixel;
   } tlr_rsp_type;

endpackage

FILE: rtl/thick_line_rasterizer.sv
// A step item's pixel is registered and shows on rsp the cycle after it is accepted.
// One pixel per cycle along a line while rsp is not stalled; a step that opens a new
// positive offset pass then runs the pass-existence square test (MI, SQI, CMP).
// A start item keeps the sequencer busy through states LX to CMP of the shared multiplier
// (width limit, then the first pass test). Synchronous reset leaves it idle.
// ----------------------------------------------------------------------------
// thick_line_rasterizer: Bresenham line widened by parallel offset copies
// A small sequencer drives one shared multiplier that forms the squared
// width limit on start and the squared offset test before each new positive pass.
// ----------------------------------------------------------------------------
module thick_line_rasterizer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  tlr_pkg::tlr_req_type req_item,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tlr_pkg::tlr_rsp_type rsp_item
);
   import tlr_pkg::*;

   // sequencer states
   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_LX   = 4'd1;
   localparam logic [3:0] ST_SQX  = 4'd2;
   localparam logic [3:0] ST_LY   = 4'd3;
   localparam logic [3:0] ST_SQY  = 4'd4;
   localparam logic [3:0] ST_SUM  = 4'd5;
   localparam logic [3:0] ST_MI   = 4'd6;
   localparam logic [3:0] ST_SQI  = 4'd7;
   localparam logic [3:0] ST_CMP  = 4'd8;

   function automatic logic signed [ERR_BITS-1:0] err_init(
      input logic [COORD_BITS-1:0] mnr,
      input logic [COORD_BITS-1:0] mjr
   );
      logic signed [ERR_BITS-1:0] m2;
      logic signed [ERR_BITS-1:0] mj;
      m2 = $signed({2'b00, mnr, 1'b0});
      mj = $signed({3'b000, mjr});
      return m2 - mj;
   endfunction

   logic [3:0]                   state_ff, state_in;
   logic                         busy_ff, busy_in;
   logic signed [CUR_BITS-1:0]   cur_x_ff, cur_x_in;
   logic signed [CUR_BITS-1:0]   cur_y_ff, cur_y_in;
   logic [COORD_BITS-1:0]        base_x_ff, base_x_in;
   logic [COORD_BITS-1:0]        base_y_ff, base_y_in;
   logic [COORD_BITS-1:0]        end_major_ff, end_major_in;
   logic [COORD_BITS-1:0]        dx_ff, dx_in;
   logic [COORD_BITS-1:0]        dy_ff, dy_in;
   logic [1:0]                   signs_ff, signs_in;
   logic                         steep_ff, steep_in;
   logic signed [ERR_BITS-1:0]   err_ff, err_in;
   logic [IDX_BITS-1:0]          idx_ff, idx_in;
   logic                         neg_ff, neg_in;
   logic [LIM_BITS-1:0]          limit_ff, limit_in;
   logic [WIDTH_BITS-1:0]        wm1_ff, wm1_in;
   logic [PROD_BITS-1:0]         prod_ff, prod_in;
   logic                         more_ff, more_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   tlr_rsp_type                  rsp_item_ff, rsp_item_in;

   logic                         req_accept;
   logic                         step_emit;
   logic [COORD_BITS-1:0]        s_dx, s_dy;
   logic                         s_steep;
   logic [CUR_BITS-1:0]          major_pos;
   logic                         at_end;
   logic                         advance_i;
   logic                         last;
   logic [COORD_BITS-1:0]        mnr_d, mjr_d;
   logic signed [ERR_BITS-1:0]   err_minor2, err_diff2;
   logic signed [CUR_BITS-1:0]   x_step, y_step;
   logic signed [CUR_BITS-1:0]   off;
   logic [CUR_BITS-1:0]          off_mag;
   logic [IDX_BITS:0]            idx_p1;
   logic [MUL_BITS-1:0]          mul_a, mul_b;
   logic [PROD_BITS-1:0]         mul_p;
   logic [MUL_BITS-1:0]          prod_low;
   logic [PROD_BITS-1:0]         lim_ext;

   // handshake
   assign req_ready  = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_accept = req_valid && req_ready;
   assign step_emit  = req_accept && (req_item.req_type == REQ_STEP) && busy_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_item   = rsp_item_ff;

   // start geometry from the request fields
   always_comb begin
      s_dx    = (req_item.x_start < req_item.x_end) ? req_item.x_end - req_item.x_start
                                                    : req_item.x_start - req_item.x_end;
      s_dy    = (req_item.y_start < req_item.y_end) ? req_item.y_end - req_item.y_start
                                                    : req_item.y_start - req_item.y_end;
      s_steep = s_dy > s_dx;
   end

   // position along the current pass
   assign major_pos = steep_ff ? cur_y_ff : cur_x_ff;
   assign at_end    = major_pos == {{(CUR_BITS-COORD_BITS){1'b0}}, end_major_ff};
   assign advance_i = (idx_ff == '0) || neg_ff;
   assign last      = at_end && advance_i && !more_ff;

   // error term increments
   assign mnr_d      = steep_ff ? dx_ff : dy_ff;
   assign mjr_d      = steep_ff ? dy_ff : dx_ff;
   assign err_minor2 = $signed({2'b00, mnr_d, 1'b0});
   assign err_diff2  = err_minor2 - $signed({2'b00, mjr_d, 1'b0});
   assign x_step     = signs_ff[0] ? -CUR_BITS'(1) : CUR_BITS'(1);
   assign y_step     = signs_ff[1] ? -CUR_BITS'(1) : CUR_BITS'(1);

   // shared multiplier and its operand select
   assign prod_low = prod_ff[MUL_BITS-1:0];
   assign idx_p1   = {1'b0, idx_ff} + (IDX_BITS+1)'(1);
   assign lim_ext  = {{(PROD_BITS-LIM_BITS){1'b0}}, limit_ff};
   always_comb begin
      unique case (state_ff)
         ST_LX: begin
            mul_a = {{(MUL_BITS-WIDTH_BITS){1'b0}}, wm1_ff};
            mul_b = {{(MUL_BITS-COORD_BITS){1'b0}}, dx_ff};
         end
         ST_LY: begin
            mul_a = {{(MUL_BITS-WIDTH_BITS){1'b0}}, wm1_ff};
            mul_b = {{(MUL_BITS-COORD_BITS){1'b0}}, dy_ff};
         end
         ST_MI: begin
            mul_a = {{(MUL_BITS-IDX_BITS-1){1'b0}}, idx_p1};
            mul_b = {{(MUL_BITS-COORD_BITS){1'b0}}, mjr_d};
         end
         default: begin
            mul_a = prod_low;
            mul_b = prod_low;
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // next state
   always_comb begin
      state_in     = state_ff;
      busy_in      = busy_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      base_x_in    = base_x_ff;
      base_y_in    = base_y_ff;
      end_major_in = end_major_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      signs_in     = signs_ff;
      steep_in     = steep_ff;
      err_in       = err_ff;
      idx_in       = idx_ff;
      neg_in       = neg_ff;
      limit_in     = limit_ff;
      wm1_in       = wm1_ff;
      prod_in      = mul_p;
      more_in      = more_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_item_in  = rsp_item_ff;
      off_mag      = '0;
      off          = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_item.req_type == REQ_START)) begin
               // latch the new line, centre pass first
               base_x_in    = req_item.x_start;
               base_y_in    = req_item.y_start;
               dx_in        = s_dx;
               dy_in        = s_dy;
               signs_in     = {!(req_item.y_start < req_item.y_end),
                               !(req_item.x_start < req_item.x_end)};
               steep_in     = s_steep;
               end_major_in = s_steep ? req_item.y_end : req_item.x_end;
               wm1_in       = (req_item.line_width == '0) ? '0
                                                          : req_item.line_width - 1'b1;
               idx_in       = '0;
               neg_in       = 1'b0;
               cur_x_in     = {{(CUR_BITS-COORD_BITS){1'b0}}, req_item.x_start};
               cur_y_in     = {{(CUR_BITS-COORD_BITS){1'b0}}, req_item.y_start};
               err_in       = s_steep ? err_init(s_dx, s_dy) : err_init(s_dy, s_dx);
               busy_in      = 1'b1;
               state_in     = ST_LX;
            end else if (step_emit) begin
               rsp_valid_in           = 1'b1;
               rsp_item_in.pixel_x    = cur_x_ff[PIX_BITS-1:0];
               rsp_item_in.pixel_y    = cur_y_ff[PIX_BITS-1:0];
               rsp_item_in.last_pixel = last;
               if (!at_end) begin
                  // one bresenham step
                  if (err_ff[ERR_BITS-1]) begin
                     err_in = err_ff + err_minor2;
                  end else begin
                     err_in = err_ff + err_diff2;
                     if (steep_ff) begin
                        cur_x_in = cur_x_ff + x_step;
                     end else begin
                        cur_y_in = cur_y_ff + y_step;
                     end
                  end
                  if (steep_ff) begin
                     cur_y_in = cur_y_ff + y_step;
                  end else begin
                     cur_x_in = cur_x_ff + x_step;
                  end
               end else if (last) begin
                  busy_in = 1'b0;
               end else begin
                  // open the next offset pass
                  if (advance_i) begin
                     idx_in   = idx_ff + 1'b1;
                     neg_in   = 1'b0;
                     state_in = ST_MI;
                  end else begin
                     neg_in = 1'b1;
                  end
                  off_mag  = {{(CUR_BITS-IDX_BITS){1'b0}}, idx_in};
                  off      = neg_in ? -$signed(off_mag) : $signed(off_mag);
                  cur_x_in = $signed({{(CUR_BITS-COORD_BITS){1'b0}}, base_x_ff})
                             + (steep_ff ? off : '0);
                  cur_y_in = $signed({{(CUR_BITS-COORD_BITS){1'b0}}, base_y_ff})
                             + (steep_ff ? '0 : off);
                  err_in   = err_init(mnr_d, mjr_d);
               end
            end
         end
         ST_LX:  state_in = ST_SQX;
         ST_SQX: state_in = ST_LY;
         ST_LY: begin
            limit_in = prod_ff[LIM_BITS-1:0];
            state_in = ST_SQY;
         end
         ST_SQY: state_in = ST_SUM;
         ST_SUM: begin
            limit_in = limit_ff + prod_ff[LIM_BITS-1:0];
            state_in = ST_MI;
         end
         ST_MI:  state_in = ST_SQI;
         ST_SQI: state_in = ST_CMP;
         ST_CMP: begin
            // (2*(i+1)*major)^2 < limit
            more_in  = {prod_ff[PROD_BITS-3:0], 2'b00} < lim_ext;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cur_x_ff     <= cur_x_in;
      cur_y_ff     <= cur_y_in;
      base_x_ff    <= base_x_in;
      base_y_ff    <= base_y_in;
      end_major_ff <= end_major_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      signs_ff     <= signs_in;
      steep_ff     <= steep_in;
      err_ff       <= err_in;
      idx_ff       <= idx_in;
      neg_ff       <= neg_in;
      limit_ff     <= limit_in;
      wm1_ff       <= wm1_in;
      prod_ff      <= prod_in;
      more_ff      <= more_in;
      rsp_item_ff  <= rsp_item_in;
   end

   // checks
   a_busy_when_sequencing: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (busy_ff && !req_ready))
      else $error("sequencer running without a line or while ready");

   a_start_runs_limit: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_item.req_type == REQ_START)) |=> (state_ff == ST_LX))
      else $error("start item did not launch width limit sequence");

   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      (step_emit && last) |=> (!busy_ff && rsp_valid_ff && rsp_item_ff.last_pixel))
      else $error("final pixel did not end the line");

   a_no_emit_when_idle: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !busy_ff && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("item emitted with no line in progress");

endmodule

FILE: tb/thick_line_rasterizer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// thick_line_rasterizer_tb: self-checking bench for the thick line rasterizer
// Drives start and step items with random gaps and output stalls. A pixel
// tracker walks the same Bresenham passes to predict each emitted pixel,
// and every pixel that leaves the block is checked against it in order.
// ----------------------------------------------------------------------------
module thick_line_rasterizer_tb;
   import tlr_pkg::*;

   // pixel tracker: follows the centre line and offset passes of one line
   class raster_scoreboard;
      bit          busy;
      int          cur_x, cur_y;
      int          base_x, base_y;
      int          end_major;
      int          dx, dy;
      bit          neg_x, neg_y;
      bit          steep;
      int          err;
      int          offset_idx;
      bit          offset_neg;
      longint      limit;
      tlr_rsp_type pixel_q[$];
      int          errors;

      // squared test in place of sqrt: does an offset pass i exist
      function bit pass_exists(int i);
         longint m;
         longint t;
         m = longint'(steep ? dy : dx);
         t = 2 * longint'(i) * m;
         return t * t < limit;
      endfunction

      function void begin_pass();
         int off;
         off = offset_neg ? -offset_idx : offset_idx;
         cur_x = base_x + (steep ? off : 0);
         cur_y = base_y + (steep ? 0 : off);
         err = steep ? 2 * dx - dy : 2 * dy - dx;
      endfunction

      function void note_request(tlr_req_type r);
         int          w, xs, ys, xe, ye, major;
         bit          at_end, advance, is_last;
         tlr_rsp_type px;
         if (r.req_type == REQ_START) begin
            xs = int'(r.x_start);
            ys = int'(r.y_start);
            xe = int'(r.x_end);
            ye = int'(r.y_end);
            w = (r.line_width == 0) ? 1 : int'(r.line_width);
            base_x = xs;
            base_y = ys;
            dx = (xs < xe) ? xe - xs : xs - xe;
            dy = (ys < ye) ? ye - ys : ys - ye;
            neg_x = !(xs < xe);
            neg_y = !(ys < ye);
            steep = dy > dx;
            end_major = steep ? ye : xe;
            limit = longint'(w - 1) * (w - 1) * (longint'(dx) * dx + longint'(dy) * dy);
            offset_idx = 0;
            offset_neg = 1'b0;
            begin_pass();
            busy = 1'b1;
         end else if (busy) begin
            major = steep ? cur_y : cur_x;
            at_end = (major == end_major);
            advance = (offset_idx == 0) || offset_neg;
            is_last = at_end && advance && !pass_exists(offset_idx + 1);
            px.pixel_x = cur_x[PIX_BITS-1:0];
            px.pixel_y = cur_y[PIX_BITS-1:0];
            px.last_pixel = is_last;
            pixel_q.push_back(px);
            // bresenham step along the major axis
            if (!at_end) begin
               if (steep) begin
                  if (err < 0) begin
                     err += 2 * dx;
                  end else begin
                     err += 2 * (dx - dy);
                     cur_x += neg_x ? -1 : 1;
                  end
                  cur_y += neg_y ? -1 : 1;
               end else begin
                  if (err < 0) begin
                     err += 2 * dy;
                  end else begin
                     err += 2 * (dy - dx);
                     cur_y += neg_y ? -1 : 1;
                  end
                  cur_x += neg_x ? -1 : 1;
               end
            end else if (is_last) begin
               busy = 1'b0;
            end else begin
               // +i pass first, then -i, then move to i+1
               if (advance) begin
                  offset_idx++;
                  offset_neg = 1'b0;
               end else begin
                  offset_neg = 1'b1;
               end
               begin_pass();
            end
         end
      endfunction

      function void compare_field(string name, int exp_val, int act_val);
         if (exp_val != act_val) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_val, act_val);
            errors++;
         end
      endfunction

      function void check_pixel(tlr_rsp_type p);
         tlr_rsp_type exp_px;
         if (pixel_q.size() == 0) begin
            $display("%0t: unexpected pixel, expected none, actual (%0d, %0d, last %0d)",
                     $time, p.pixel_x, p.pixel_y, p.last_pixel);
            errors++;
            return;
         end
         exp_px = pixel_q.pop_front();
         compare_field("pixel_x", int'(exp_px.pixel_x), int'(p.pixel_x));
         compare_field("pixel_y", int'(exp_px.pixel_y), int'(p.pixel_y));
         compare_field("last_pixel", int'(exp_px.last_pixel), int'(p.last_pixel));
      endfunction
   endclass

   localparam int ITEM_TARGET = 750;
   localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
   localparam int LINE_W_MAX  = (1 << WIDTH_BITS) - 1;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   tlr_req_type req_item;
   logic        rsp_valid;
   logic        rsp_ready;
   tlr_rsp_type rsp_item;

   raster_scoreboard sb = new();
   int idle_pct;
   int stall_pct;
   int items_done;

   thick_line_rasterizer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   // clock
   initial clock = 1'b0;
   always #4 clock = ~clock;

   // output stalls
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // pixel monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_pixel(rsp_item);
      end
   end

   // send one item, with random idle cycles ahead of it
   task automatic send_req(input tlr_req_type item);
      while ($urandom_range(0, 99) < idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_item <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (item.req_type == REQ_START || sb.busy) items_done++;
      sb.note_request(item);
   endtask

   task automatic start_line(input int xs, input int ys, input int xe, input int ye,
                             input int w);
      tlr_req_type r;
      r.req_type = REQ_START;
      r.x_start = COORD_BITS'(xs);
      r.y_start = COORD_BITS'(ys);
      r.x_end = COORD_BITS'(xe);
      r.y_end = COORD_BITS'(ye);
      r.line_width = WIDTH_BITS'(w);
      send_req(r);
   endtask

   // step item; unused fields carry random noise
   task automatic step_once();
      tlr_req_type r;
      r.req_type = REQ_STEP;
      r.x_start = COORD_BITS'($urandom_range(0, COORD_MAX));
      r.y_start = COORD_BITS'($urandom_range(0, COORD_MAX));
      r.x_end = COORD_BITS'($urandom_range(0, COORD_MAX));
      r.y_end = COORD_BITS'($urandom_range(0, COORD_MAX));
      r.line_width = WIDTH_BITS'($urandom_range(0, LINE_W_MAX));
      send_req(r);
   endtask

   task automatic step_n(input int n);
      repeat (n) step_once();
   endtask

   // short offset from a start coordinate, kept on screen
   function automatic int near_coord(int c, int span);
      int d;
      d = $urandom_range(0, span);
      if (($urandom_range(0, 1) && c + d <= COORD_MAX) || c < d) return c + d;
      return c - d;
   endfunction

   // one random line: mostly short ones run to the end, a few long or wide
   task automatic random_line();
      int mode, xs, ys, xe, ye, w, max_steps, n;
      mode = $urandom_range(0, 19);
      xs = $urandom_range(0, COORD_MAX);
      ys = $urandom_range(0, COORD_MAX);
      if (mode == 0) begin
         // anywhere on screen, any width, abandoned early
         xe = $urandom_range(0, COORD_MAX);
         ye = $urandom_range(0, COORD_MAX);
         w = $urandom_range(0, LINE_W_MAX);
         max_steps = $urandom_range(1, 40);
      end else if (mode == 1) begin
         // very wide, very short
         xe = near_coord(xs, 1);
         ye = near_coord(ys, 1);
         w = $urandom_range(40, LINE_W_MAX);
         max_steps = 1 << 20;
      end else begin
         xe = near_coord(xs, 6);
         ye = near_coord(ys, 6);
         w = $urandom_range(0, 8);
         max_steps = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 20) : 1 << 20;
      end
      start_line(xs, ys, xe, ye, w);
      n = 0;
      while (sb.busy && n < max_steps) begin
         step_once();
         n++;
      end
      // stray steps while idle are ignored by the block
      if (!sb.busy && $urandom_range(0, 4) == 0) step_n($urandom_range(1, 2));
   endtask

   // main sequence
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_item = '0;
      rsp_ready = 1'b0;
      idle_pct = 0;
      stall_pct = 0;
      items_done = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: idle step, extreme corners, restart while busy, width zero,
      // single point, vertical line, offset pass below the screen edge
      step_once();
      start_line(0, 0, COORD_MAX, COORD_MAX, LINE_W_MAX);
      step_n(2);
      start_line(COORD_MAX, COORD_MAX, 0, 0, LINE_W_MAX);
      step_once();
      start_line(COORD_MAX, 1, COORD_MAX, 0, 0);
      step_n(3);
      start_line(7, 7, 7, 7, LINE_W_MAX);
      step_once();
      start_line(0, 1, 1, 0, 3);
      step_n(6);

      // random lines under four idling patterns
      for (int phase = 0; phase < 4; phase++) begin
         unique case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 71; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 71; end
            default: begin idle_pct = 17; stall_pct = 17; end
         endcase
         while (items_done < ITEM_TARGET * (phase + 1) / 4) random_line();
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pixel_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // run limit
   initial begin
      #8_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
